@@ src/gregorian_date_calculator_defines.svh @@
// Assertion macros shared by the date calculator RTL.
`ifndef GREGORIAN_DATE_CALCULATOR_DEFINES_SVH
`define GREGORIAN_DATE_CALCULATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define GDC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("date calculator assertion failed");
`define GDC_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("date calculator forbidden condition seen");
`else
`define GDC_ASSERT(lbl, clk, rst_n, prop)
`define GDC_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

@@ src/gdc_pkg.sv @@
// Shared widths, calendar tables and helper functions for the date calculator.
package gdc_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned AddW   = 12;
  localparam int unsigned JdnW   = 23;
  localparam int unsigned DowW   = 3;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned MlenW  = 5;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [YearW-1:0] YearMax = '1;
  localparam logic [DayW-1:0]  DayMax  = 5'd31;

  localparam int unsigned EpochYears = 4800;
  localparam int unsigned JdnBias    = 32045;

  // cumulative days before each month, January first
  localparam logic [8:0] DaysBefore [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // (153 * mm + 2) / 5 for a March-based month index
  localparam logic [8:0] MarchOffset [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  typedef logic [14:0] ywide_t;
  typedef logic [8:0]  cent_t;

  function automatic logic [MonthW-1:0] clamp_month(input logic [MonthW-1:0] m);
    logic [MonthW-1:0] r;
    r = m;
    if (m == '0) begin
      r = MonthJan;
    end else if (m > MonthDec) begin
      r = MonthDec;
    end
    return r;
  endfunction

  // exact floor(x / 100) for x below 43690
  function automatic cent_t div100(input ywide_t x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[27:19];
  endfunction

  // q must be floor(y / 100)
  function automatic logic leap_from(input ywide_t y, input cent_t q);
    ywide_t r;
    r = y - 15'(q) * 15'd100;
    return ((y[1:0] == 2'b00) && (r != '0)) || ((r == '0) && (q[1:0] == 2'b00));
  endfunction

  function automatic logic [MlenW-1:0] month_len(input logic leap,
                                                  input logic [MonthW-1:0] m);
    logic [MlenW-1:0] r;
    case (m) inside
      MonthFeb:                               r = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: r = 5'd30;
      default:                                r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

@@ src/gdc_calendar.sv @@
// Julian day number, weekday, ordinal day, month length and leap flag pipeline.
module gdc_calendar (
  input  logic                          clk_i,
  input  logic [gdc_pkg::YearW-1:0]     year_i,
  input  logic [gdc_pkg::MonthW-1:0]    month_i,
  input  logic [gdc_pkg::DayW-1:0]      day_i,
  output logic [gdc_pkg::JdnW-1:0]      julian_day_o,
  output logic [gdc_pkg::DowW-1:0]      day_of_week_o,
  output logic [gdc_pkg::DoyW-1:0]      day_of_year_o,
  output logic [gdc_pkg::MlenW-1:0]     days_in_month_o,
  output logic                          leap_year_o
);
  import gdc_pkg::*;

  // sum of base-8 digits, folded down to the residue mod 7
  function automatic logic [2:0] mod7(input logic [JdnW-1:0] x);
    logic [23:0] w;
    logic [5:0]  s;
    logic [3:0]  f;
    w = 24'(x);
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(w[3*i +: 3]);
    end
    f = 4'(s[5:3]) + 4'(s[2:0]);
    if (f >= 4'd14) begin
      f = f - 4'd14;
    end else if (f >= 4'd7) begin
      f = f - 4'd7;
    end
    return f[2:0];
  endfunction

  // stage 1
  logic [MonthW-1:0] mon;
  logic              early;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] mon_d, mon_q;
  logic [DayW-1:0]   day_q;
  ywide_t            y_d, y_q;
  logic [3:0]        mm_d, mm_q;
  cent_t             qy_d, qy_q;
  cent_t             qyr_d, qyr_q;

  always_comb begin
    mon   = clamp_month(month_i);
    mon_d = mon;
    early = (mon <= MonthFeb);
    y_d   = 15'(year_i) + 15'(EpochYears) - 15'(early);
    mm_d  = early ? (mon + 4'd9) : (mon - 4'd3);
    qy_d  = div100(y_d);
    qyr_d = div100(15'(year_i));
  end

  always_ff @(posedge clk_i) begin
    year_q <= year_i;
    mon_q  <= mon_d;
    day_q  <= day_i;
    y_q    <= y_d;
    mm_q   <= mm_d;
    qy_q   <= qy_d;
    qyr_q  <= qyr_d;
  end

  // stage 2
  logic [23:0]        jdn_sum;
  logic [JdnW-1:0]    jdn_d, jdn_q;
  logic               leap_d, leap_q;
  logic [MlenW-1:0]   mlen_d, mlen_q;
  logic [DoyW-1:0]    doy_d, doy_q;

  always_comb begin
    leap_d  = leap_from(15'(year_q), qyr_q);
    jdn_sum = 24'(day_q) + 24'(MarchOffset[mm_q]) + 24'(y_q) * 24'd365
            + 24'(y_q >> 2) + 24'(qy_q >> 2) - 24'(qy_q) - 24'(JdnBias);
    jdn_d   = jdn_sum[JdnW-1:0];
    mlen_d  = month_len(leap_d, mon_q);
    doy_d   = DaysBefore[mon_q - 4'd1] + 9'((mon_q > MonthFeb) && leap_d) + 9'(day_q);
  end

  always_ff @(posedge clk_i) begin
    jdn_q  <= jdn_d;
    leap_q <= leap_d;
    mlen_q <= mlen_d;
    doy_q  <= doy_d;
  end

  // stage 3: result registers
  always_ff @(posedge clk_i) begin
    julian_day_o    <= jdn_q;
    day_of_week_o   <= mod7(jdn_q) + 3'd1;
    day_of_year_o   <= doy_q;
    days_in_month_o <= mlen_q;
    leap_year_o     <= leap_q;
  end

endmodule

@@ src/gdc_shift.sv @@
// Date shift by years and months with day clamping, three register stages.
module gdc_shift (
  input  logic                          clk_i,
  input  logic [gdc_pkg::YearW-1:0]     year_i,
  input  logic [gdc_pkg::MonthW-1:0]    month_i,
  input  logic [gdc_pkg::DayW-1:0]      day_i,
  input  logic [gdc_pkg::AddW-1:0]      months_to_add_i,
  input  logic [gdc_pkg::AddW-1:0]      years_to_add_i,
  output logic [gdc_pkg::YearW-1:0]     shifted_year_o,
  output logic [gdc_pkg::MonthW-1:0]    shifted_month_o,
  output logic [gdc_pkg::DayW-1:0]      shifted_day_o
);
  import gdc_pkg::*;

  // stage 1: month offset and its carry into years
  logic [MonthW-1:0] mon;
  logic [12:0]       v_d, v_q;
  ywide_t            ysum_d, ysum_q;
  logic [20:0]       p12;
  logic [8:0]        q_d, q_q;
  logic [DayW-1:0]   day1_q;

  always_comb begin
    mon    = clamp_month(month_i);
    v_d    = 13'(months_to_add_i) + 13'(mon - 4'd1);
    ysum_d = 15'(year_i) + 15'(years_to_add_i);
    // floor(v / 12) as floor(floor(v / 4) / 3)
    p12    = 21'(v_d[12:2]) * 21'd683;
    q_d    = p12[19:11];
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    ysum_q <= ysum_d;
    q_q    <= q_d;
    day1_q <= day_i;
  end

  // stage 2: target month and year
  logic [MonthW-1:0] sm_d, sm_q;
  ywide_t            sy_d, sy_q;
  cent_t             qs_d, qs_q;
  logic [12:0]       rem;
  logic [DayW-1:0]   day2_q;

  always_comb begin
    rem  = v_q - 13'(q_q) * 13'd12;
    sm_d = rem[MonthW-1:0] + 4'd1;
    sy_d = ysum_q + 15'(q_q);
    qs_d = div100(sy_d);
  end

  always_ff @(posedge clk_i) begin
    sm_q   <= sm_d;
    sy_q   <= sy_d;
    qs_q   <= qs_d;
    day2_q <= day1_q;
  end

  // stage 3: clamp day to target month, saturate on year overflow
  logic             sleap;
  logic [MlenW-1:0] tlen;

  always_comb begin
    sleap = leap_from(sy_q, qs_q);
    tlen  = month_len(sleap, sm_q);
  end

  always_ff @(posedge clk_i) begin
    if (sy_q[YearW]) begin
      shifted_year_o  <= YearMax;
      shifted_month_o <= MonthDec;
      shifted_day_o   <= DayMax;
    end else begin
      shifted_year_o  <= sy_q[YearW-1:0];
      shifted_month_o <= sm_q;
      shifted_day_o   <= (day2_q < tlen) ? day2_q : tlen;
    end
  end

endmodule

@@ src/gregorian_date_calculator.sv @@
// Top level of the Gregorian date calculator: input word register, pipelines, strobe.
//
// The block takes one date word per clock: busy_o stays low, so a word is taken
// at every edge where start_i is high. Each word yields exactly one result word,
// marked by done_o for a single cycle. done_o rises together with the result, which is
// carried through the input register, two arithmetic stages and the result register.
// Results come out in the order the words went in. The receiver cannot stall and must
// take each result in its strobe cycle. The calendar path gives the Julian day number,
// ISO weekday, day of year, month length and leap flag of the input date; the shift
// path moves the date forward by years_to_add_i*12 + months_to_add_i months, clamps
// the day to the target month, and saturates at year 16383.
`include "gregorian_date_calculator_defines.svh"

module gregorian_date_calculator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [gdc_pkg::YearW-1:0]     year_i,
  input  logic [gdc_pkg::MonthW-1:0]    month_i,
  input  logic [gdc_pkg::DayW-1:0]      day_i,
  input  logic [gdc_pkg::AddW-1:0]      months_to_add_i,
  input  logic [gdc_pkg::AddW-1:0]      years_to_add_i,
  output logic                          done_o,
  output logic [gdc_pkg::YearW-1:0]     shifted_year_o,
  output logic [gdc_pkg::MonthW-1:0]    shifted_month_o,
  output logic [gdc_pkg::DayW-1:0]      shifted_day_o,
  output logic [gdc_pkg::JdnW-1:0]      julian_day_o,
  output logic [gdc_pkg::DowW-1:0]      day_of_week_o,
  output logic [gdc_pkg::DoyW-1:0]      day_of_year_o,
  output logic [gdc_pkg::MlenW-1:0]     days_in_month_o,
  output logic                          leap_year_o
);
  import gdc_pkg::*;

  logic              accept;
  logic [3:0]        valid_d, valid_q;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;
  logic [AddW-1:0]   madd_q;
  logic [AddW-1:0]   yadd_q;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign valid_d = {valid_q[2:0], accept};
  assign done_o  = valid_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      year_q  <= year_i;
      month_q <= month_i;
      day_q   <= day_i;
      madd_q  <= months_to_add_i;
      yadd_q  <= years_to_add_i;
    end
  end

  gdc_calendar u_calendar (
    .clk_i           (clk_i),
    .year_i          (year_q),
    .month_i         (month_q),
    .day_i           (day_q),
    .julian_day_o    (julian_day_o),
    .day_of_week_o   (day_of_week_o),
    .day_of_year_o   (day_of_year_o),
    .days_in_month_o (days_in_month_o),
    .leap_year_o     (leap_year_o)
  );

  gdc_shift u_shift (
    .clk_i           (clk_i),
    .year_i          (year_q),
    .month_i         (month_q),
    .day_i           (day_q),
    .months_to_add_i (madd_q),
    .years_to_add_i  (yadd_q),
    .shifted_year_o  (shifted_year_o),
    .shifted_month_o (shifted_month_o),
    .shifted_day_o   (shifted_day_o)
  );

  `GDC_ASSERT(a_latency, clk_i, rst_ni, (start_i && !busy_o) |-> ##4 done_o)
  `GDC_ASSERT_NEVER(a_dow_zero, clk_i, rst_ni, done_o && (day_of_week_o == 3'd0))
  `GDC_ASSERT(a_smonth_rng, clk_i, rst_ni, done_o |-> (shifted_month_o >= 4'd1 && shifted_month_o <= 4'd12))
  `GDC_ASSERT(a_feb29_leap, clk_i, rst_ni, (done_o && days_in_month_o == 5'd29) |-> leap_year_o)

endmodule
